[hdl/ucf_pkg.sv]
// Package for the UART command-frame motor controller.
// Holds the channel word types, the parser phases, the command codes and the reply helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ucf_pkg;

  // Bytes of the payload that a command ever reads (code plus four operand bytes).
  localparam int unsigned CMD_BYTES     = 5;
  localparam int unsigned PAYLOAD_DEPTH = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned REPLY_LEN     = 6;

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] HDR_BYTE   = 8'haa;
  localparam logic [7:0] REPLY_TYPE = 8'h02;
  localparam logic [7:0] REPLY_PAD  = 8'h00;
  localparam logic [7:0] REPLY_END  = 8'h0a;
  localparam logic [7:0] REPLY_OK   = 8'hff;
  localparam logic [7:0] REPLY_BAD  = 8'hee;
  localparam logic [7:0] OWN_ADDR_RESET = 8'h01;

  localparam logic [15:0] BRAKE_PULSE   = 16'h00ee;
  localparam logic [15:0] BRAKE_RELEASE = 16'h01f0;

  localparam logic [7:0] CMD_REPLY   = 8'h01;
  localparam logic [7:0] CMD_FWD     = 8'h02;
  localparam logic [7:0] CMD_REV     = 8'h03;
  localparam logic [7:0] CMD_BRAKE   = 8'h04;
  localparam logic [7:0] CMD_LEFT    = 8'h05;
  localparam logic [7:0] CMD_RIGHT   = 8'h06;
  localparam logic [7:0] CMD_FWD_SPL = 8'h07;
  localparam logic [7:0] CMD_REV_SPL = 8'h08;
  localparam logic [7:0] CMD_BAL_1   = 8'h09;
  localparam logic [7:0] CMD_BAL_2   = 8'h0a;
  localparam logic [7:0] CMD_BAL_3   = 8'h0b;

  // Status characters '2' .. '9', 'a', 'b'.
  localparam logic [7:0] ST_FWD     = 8'h32;
  localparam logic [7:0] ST_REV     = 8'h33;
  localparam logic [7:0] ST_BRAKE   = 8'h34;
  localparam logic [7:0] ST_LEFT    = 8'h35;
  localparam logic [7:0] ST_RIGHT   = 8'h36;
  localparam logic [7:0] ST_FWD_SPL = 8'h37;
  localparam logic [7:0] ST_REV_SPL = 8'h38;
  localparam logic [7:0] ST_BAL_1   = 8'h39;
  localparam logic [7:0] ST_BAL_2   = 8'h61;
  localparam logic [7:0] ST_BAL_3   = 8'h62;

  localparam logic [3:0] DIR_FWD   = 4'h5;
  localparam logic [3:0] DIR_REV   = 4'ha;
  localparam logic [3:0] DIR_LEFT  = 4'h9;
  localparam logic [3:0] DIR_RIGHT = 4'h6;
  localparam logic [3:0] DIR_OFF   = 4'h0;

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_DATA
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
  } rx_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [3:0]  dir_bits;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [1:0]  balance_mode;
    logic        last;
  } tx_t;

  // One complete frame as handed from the parser to the executor.
  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] pair_a;
    logic [15:0] pair_b;
  } cmd_t;

  function automatic logic [7:0] reply_byte(input logic [2:0] step, input logic [7:0] code);
    logic [7:0] r;
    case (step)
      3'd0:    r = SYNC_BYTE;
      3'd1:    r = HDR_BYTE;
      3'd2:    r = REPLY_TYPE;
      3'd3:    r = code;
      3'd4:    r = REPLY_PAD;
      default: r = REPLY_END;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/ucf_rx_if.sv]
// Receive byte channel: valid, ready and one received byte with its error flag.
// Depends on ucf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ucf_rx_if;
  logic         valid;
  logic         ready;
  ucf_pkg::rx_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ucf_tx_if.sv]
// Result channel: valid, ready and one result word (transmit byte and motor state).
// Depends on ucf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ucf_tx_if;
  logic         valid;
  logic         ready;
  ucf_pkg::tx_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ucf_cfg_if.sv]
// Configuration write channel: valid, ready and the node address.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ucf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ucf_front.sv]
// Frame parser: checks sync and header, collects the payload and pushes finished frames.
// Depends on ucf_pkg, ucf_rx_if and ucf_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module ucf_front #(
  parameter int unsigned PAYLOAD_DEPTH = ucf_pkg::PAYLOAD_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ucf_rx_if.sink        rx_i,
  ucf_cfg_if.sink       cfg_i,
  input  wire logic     q_full_i,
  output ucf_pkg::cmd_t q_data_o,
  output logic          q_push_o
);

  localparam int unsigned IdxW = $clog2(PAYLOAD_DEPTH + 1);

  ucf_pkg::phase_e phase_q, phase_d;
  logic            header_ok_q, header_ok_d;
  logic [7:0]      left_q, left_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      store_q [ucf_pkg::CMD_BYTES];
  logic [7:0]      store_d [ucf_pkg::CMD_BYTES];
  logic [7:0]      addr_q;
  logic            take;
  logic [7:0]      b;

  assign rx_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign b           = rx_i.data.rx_byte;
  assign take        = rx_i.valid && !q_full_i && !rx_i.data.rx_error;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      case (phase_q)
        ucf_pkg::PH_SYNC: phase_d = (b == ucf_pkg::SYNC_BYTE) ? ucf_pkg::PH_HDR1 : ucf_pkg::PH_SYNC;
        ucf_pkg::PH_HDR1: phase_d = ucf_pkg::PH_HDR2;
        ucf_pkg::PH_HDR2: begin
          phase_d = (header_ok_q && b == addr_q) ? ucf_pkg::PH_LEN : ucf_pkg::PH_SYNC;
        end
        ucf_pkg::PH_LEN:  phase_d = (b == 8'd0) ? ucf_pkg::PH_SYNC : ucf_pkg::PH_DATA;
        ucf_pkg::PH_DATA: phase_d = (left_q == 8'd1) ? ucf_pkg::PH_SYNC : ucf_pkg::PH_DATA;
        default:          phase_d = ucf_pkg::PH_SYNC;
      endcase
    end
  end

  // Counters, payload capture and the push of a finished frame.
  always_comb begin
    header_ok_d = header_ok_q;
    left_d      = left_q;
    idx_d       = idx_q;
    store_d     = store_q;
    q_push_o    = 1'b0;
    if (take) begin
      case (phase_q)
        ucf_pkg::PH_HDR1: header_ok_d = (b == ucf_pkg::HDR_BYTE);
        ucf_pkg::PH_HDR2: header_ok_d = 1'b0;
        ucf_pkg::PH_LEN: begin
          idx_d    = '0;
          left_d   = b;
          q_push_o = (b == 8'd0);
        end
        ucf_pkg::PH_DATA: begin
          if (idx_q < IdxW'(PAYLOAD_DEPTH)) begin
            for (int i = 0; i < ucf_pkg::CMD_BYTES; i++) begin
              if (idx_q == IdxW'(i)) begin
                store_d[i] = b;
              end
            end
            idx_d = idx_q + 1'b1;
          end
          left_d   = left_q - 8'd1;
          q_push_o = (left_q == 8'd1);
        end
        default: ;
      endcase
    end
  end

  assign q_data_o.code   = store_d[0];
  assign q_data_o.pair_a = {store_d[1], store_d[2]};
  assign q_data_o.pair_b = {store_d[3], store_d[4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ucf_pkg::PH_SYNC;
      header_ok_q <= 1'b0;
      left_q      <= '0;
      idx_q       <= '0;
      addr_q      <= ucf_pkg::OWN_ADDR_RESET;
      for (int i = 0; i < ucf_pkg::CMD_BYTES; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      header_ok_q <= header_ok_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      store_q     <= store_d;
      if (cfg_i.valid) begin
        addr_q <= cfg_i.data;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ucf_queue.sv]
// Short frame queue between the parser and the executor.
// Depends on ucf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ucf_pkg::cmd_t  push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output ucf_pkg::cmd_t       head_o
);

  localparam int unsigned PtrW = $clog2(ucf_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(ucf_pkg::QUEUE_DEPTH + 1);

  ucf_pkg::cmd_t   mem_q [ucf_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(ucf_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/ucf_back.sv]
// Command executor: holds the motor state and emits the result words of each frame.
// Depends on ucf_pkg and ucf_tx_if.
`timescale 1ns / 1ps
`default_nettype none

module ucf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire ucf_pkg::cmd_t  head_i,
  output logic                pop_o,
  ucf_tx_if.source            tx_o
);

  logic [2:0]   step_q;
  logic [3:0]   dir_q;
  logic [15:0]  cmp_a_q, cmp_b_q;
  logic [1:0]   bal_q;
  logic         out_valid_q;
  ucf_pkg::tx_t out_q, word;
  logic         emit;

  assign emit  = head_valid_i && (!out_valid_q || tx_o.ready);
  assign pop_o = emit && word.last;

  always_comb begin
    word.tx_valid     = 1'b1;
    word.tx_byte      = '0;
    word.dir_bits     = dir_q;
    word.compare_a    = cmp_a_q;
    word.compare_b    = cmp_b_q;
    word.balance_mode = bal_q;
    word.last         = 1'b1;
    case (head_i.code)
      ucf_pkg::CMD_REPLY: begin
        word.tx_byte = ucf_pkg::reply_byte(step_q, ucf_pkg::REPLY_OK);
        word.last    = (step_q == 3'(ucf_pkg::REPLY_LEN - 1));
      end
      ucf_pkg::CMD_FWD, ucf_pkg::CMD_REV, ucf_pkg::CMD_LEFT, ucf_pkg::CMD_RIGHT: begin
        word.compare_a = head_i.pair_a;
        word.compare_b = head_i.pair_a;
        case (head_i.code)
          ucf_pkg::CMD_FWD: begin
            word.dir_bits = ucf_pkg::DIR_FWD;
            word.tx_byte  = ucf_pkg::ST_FWD;
          end
          ucf_pkg::CMD_REV: begin
            word.dir_bits = ucf_pkg::DIR_REV;
            word.tx_byte  = ucf_pkg::ST_REV;
          end
          ucf_pkg::CMD_LEFT: begin
            word.dir_bits = ucf_pkg::DIR_LEFT;
            word.tx_byte  = ucf_pkg::ST_LEFT;
          end
          default: begin
            word.dir_bits = ucf_pkg::DIR_RIGHT;
            word.tx_byte  = ucf_pkg::ST_RIGHT;
          end
        endcase
      end
      ucf_pkg::CMD_FWD_SPL: begin
        word.dir_bits  = ucf_pkg::DIR_FWD;
        word.compare_a = head_i.pair_a;
        word.compare_b = head_i.pair_b;
        word.tx_byte   = ucf_pkg::ST_FWD_SPL;
      end
      ucf_pkg::CMD_REV_SPL: begin
        word.dir_bits  = ucf_pkg::DIR_REV;
        word.compare_a = head_i.pair_a;
        word.compare_b = head_i.pair_b;
        word.tx_byte   = ucf_pkg::ST_REV_SPL;
      end
      ucf_pkg::CMD_BRAKE: begin
        if (step_q == 3'd0) begin
          // Short reverse pulse: both line pairs take the inverse of the old low pair, dir_q[1:0].
          word.tx_valid  = 1'b0;
          word.dir_bits  = {~dir_q[1], ~dir_q[0], ~dir_q[1], ~dir_q[0]};
          word.compare_a = ucf_pkg::BRAKE_PULSE;
          word.compare_b = ucf_pkg::BRAKE_PULSE;
          word.last      = 1'b0;
        end else begin
          word.dir_bits  = ucf_pkg::DIR_OFF;
          word.compare_a = ucf_pkg::BRAKE_RELEASE;
          word.compare_b = ucf_pkg::BRAKE_RELEASE;
          word.tx_byte   = ucf_pkg::ST_BRAKE;
        end
      end
      ucf_pkg::CMD_BAL_1: begin
        word.balance_mode = 2'd1;
        word.tx_byte      = ucf_pkg::ST_BAL_1;
      end
      ucf_pkg::CMD_BAL_2: begin
        word.balance_mode = 2'd2;
        word.tx_byte      = ucf_pkg::ST_BAL_2;
      end
      ucf_pkg::CMD_BAL_3: begin
        word.balance_mode = 2'd3;
        word.tx_byte      = ucf_pkg::ST_BAL_3;
      end
      default: begin
        word.tx_byte = ucf_pkg::reply_byte(step_q, ucf_pkg::REPLY_BAD);
        word.last    = (step_q == 3'(ucf_pkg::REPLY_LEN - 1));
      end
    endcase
  end

  assign tx_o.valid = out_valid_q;
  assign tx_o.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      dir_q       <= '0;
      cmp_a_q     <= '0;
      cmp_b_q     <= '0;
      bal_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        dir_q       <= word.dir_bits;
        cmp_a_q     <= word.compare_a;
        cmp_b_q     <= word.compare_b;
        bal_q       <= word.balance_mode;
        step_q      <= word.last ? 3'd0 : step_q + 3'd1;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/uart_command_frame_motor_ctrl.sv]
// UART command-frame receiver and motor controller, top level.
// Takes one received byte per cycle; frame results pass the queue and a registered output.
// Results leave one word per cycle while tx is ready; a reply is 6 words, brake 2, others 1.
// Input stalls only while the two-entry frame queue is full. Reset is asynchronous, active
// low, and clears parser, queue, motor state and node address at once; no clearing pass.
// Depends on ucf_pkg, the three channel interfaces, ucf_front, ucf_queue and ucf_back.
`timescale 1ns / 1ps
`default_nettype none

module uart_command_frame_motor_ctrl #(
  parameter int unsigned PAYLOAD_DEPTH = ucf_pkg::PAYLOAD_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ucf_rx_if.sink    rx_i,
  ucf_cfg_if.sink   cfg_i,
  ucf_tx_if.source  tx_o
);

  // The parser (front) sees every byte and, when a frame is complete, pushes its
  // command code and the two operand pairs into a short queue. The executor (back)
  // pops frames and produces their result words through a registered output, so a
  // stalled transmitter holds back only the executor while the parser keeps taking
  // bytes until the queue fills.

  ucf_pkg::cmd_t push_data;
  ucf_pkg::cmd_t head;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;

  ucf_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .cfg_i    (cfg_i),
    .q_full_i (full),
    .q_data_o (push_data),
    .q_push_o (push)
  );

  ucf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The executor keeps the direction lines, both compares and the balance mode;
  // every result word carries their values after that word.
  ucf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .tx_o         (tx_o)
  );

endmodule

`default_nettype wire
